/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the compensation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/baro_pkg.sv */
// ----------------------------------------------------------------------------
// baro_pkg
// Types, constants and helper functions of the barometric compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package baro_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;
   localparam logic [2:0] REG_OSS     = 3'd5;

   // Opcodes and status codes
   localparam logic OP_TEMP    = 1'b0;
   localparam logic OP_PRESS   = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_DIV0 = 1'b1;

   // Compensation constants
   localparam logic [31:0] B6_OFFSET  = 32'd4000;
   localparam logic [31:0] P_SCALE    = 32'd50000;
   localparam logic [31:0] X3_OFFSET  = 32'd32768;
   localparam logic [31:0] P_COEF_SQ  = 32'd3038;
   localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343;   // -7357
   localparam logic [31:0] P_OFFSET   = 32'd3791;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_MUL,
      ST_T_DEN,
      ST_T_DIV,
      ST_T_FIN,
      ST_P_B6,
      ST_P_SQ,
      ST_P_X1,
      ST_P_B3,
      ST_P_AC3,
      ST_P_X3,
      ST_P_B4,
      ST_P_B7,
      ST_P_DIV,
      ST_P_P,
      ST_P_T,
      ST_P_X1B,
      ST_P_FIN,
      ST_DONE
   } state_type;

   // Divider request and status
   typedef struct packed {
      logic        start;
      logic        is_signed;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_stat_type;

   // Sign-extend a 16-bit coefficient
   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Arithmetic right shift
   function automatic logic [31:0] asr(input logic [31:0] a, input logic [4:0] k);
      logic signed [31:0] s;
      s = $signed(a);
      return 32'(s >>> k);
   endfunction

   // Signed division by 2**k, truncating toward zero
   function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
      logic [31:0] bias;
      bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return asr(a + bias, k);
   endfunction

endpackage

`default_nettype wire

/* src/baro_div.sv */
// ----------------------------------------------------------------------------
// baro_div
// Restoring 32-bit divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire baro_pkg::div_req_type req,
   output      baro_pkg::div_stat_type stat
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [32:0] rem_sh;
   logic [32:0] diff;

   // One restoring step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[31]};
      diff   = rem_sh - {1'b0, den_ff};
   end

   // Load operands on start, then advance one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = busy_ff && (cnt_ff == 5'd0);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         rem_in  = 32'd0;
         quo_in  = (req.is_signed && req.dividend[31]) ? (32'd0 - req.dividend) : req.dividend;
         den_in  = (req.is_signed && req.divisor[31]) ? (32'd0 - req.divisor) : req.divisor;
         neg_in  = req.is_signed && (req.dividend[31] ^ req.divisor[31]);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end
         rem_in = diff[32] ? rem_sh[31:0] : diff[31:0];
         quo_in = {quo_ff[30:0], ~diff[32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Fix the sign of the quotient
   always_comb begin
      stat.busy     = busy_ff;
      stat.done     = done_ff;
      stat.quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;
   end

endmodule

`default_nettype wire

/* src/barometer_temp_pressure_compensation.sv */
// Barometric sensor compensation, integer method.
// Input channel (req_*): one word per raw reading, req_opcode selects a
// temperature sample (low 16 bits of req_raw_sample) or a pressure sample.
// Result channel (rsp_*): one word per reading with the kind, the signed
// compensated value (tenths of a degree or pascals) and a status bit that
// flags a zero divisor (value then 0).
// Calibration and oversampling are written through csr_*, by the user only
// while idle; the block itself does not enforce this. A word reaches the
// result register through the sequencer states, and a zero divisor skips
// the division; the shared divider sets most of the time a word takes and
// the shared multiplier steps the rest. One word is in work at a time: a
// new word is taken only in idle; req_stall is high while the sequencer is busy.
// The result register parts the two sides: a new word may be accepted while
// a result still waits. If the receiver stalls, the finished word waits in
// the sequencer until the result register frees up.
// Reset clears the sequencer, the result valid, the stored B5 reference and
// the calibration (oversampling resets to 3).
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation
// Top level: sequencer, shared multiplier, calibration registers, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module barometer_temp_pressure_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_opcode,
   input  wire logic [23:0] req_raw_sample,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_result_kind,
   output      logic signed [31:0] rsp_compensated_value,
   output      logic        rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   baro_pkg::state_type    state_ff, state_in;
   baro_pkg::div_req_type  div_req;
   baro_pkg::div_stat_type div_stat;

   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [1:0]  oss_ff;
   logic [31:0] b5_ff, b5_in;
   logic        kind_ff;
   logic [23:0] raw_ff;
   logic [31:0] b6_ff, b6_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] t1_ff, t1_in;
   logic [31:0] b3_ff, b3_in;
   logic [31:0] b4_ff, b4_in;
   logic [31:0] p_ff, p_in;
   logic        msb_ff, msb_in;
   logic [31:0] val_ff, val_in;
   logic        stat_ff, stat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_stat_ff;
   logic        req_take;
   logic        rsp_free;

   logic [31:0] mul_a, mul_b, prod;
   logic [31:0] den, x3, b7, up, tq, x2;

   baro_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   assign req_stall = (state_ff != baro_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= 32'd0;
         ac3_ac4_ff <= 32'd0;
         ac5_ac6_ff <= 32'd0;
         b1_b2_ff   <= 32'd0;
         mc_md_ff   <= 32'd0;
         oss_ff     <= 2'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            baro_pkg::REG_AC1_AC2: ac1_ac2_ff <= csr_wdata;
            baro_pkg::REG_AC3_AC4: ac3_ac4_ff <= csr_wdata;
            baro_pkg::REG_AC5_AC6: ac5_ac6_ff <= csr_wdata;
            baro_pkg::REG_B1_B2:   b1_b2_ff   <= csr_wdata;
            baro_pkg::REG_MC_MD:   mc_md_ff   <= csr_wdata;
            baro_pkg::REG_OSS:     oss_ff     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Shared multiplier, low word only
   assign prod = mul_a * mul_b;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         baro_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (req_opcode == baro_pkg::OP_TEMP) ? baro_pkg::ST_T_MUL
                                                             : baro_pkg::ST_P_B6;
            end
         end
         baro_pkg::ST_T_MUL: state_in = baro_pkg::ST_T_DEN;
         baro_pkg::ST_T_DEN: state_in = (den == 32'd0) ? baro_pkg::ST_DONE : baro_pkg::ST_T_DIV;
         baro_pkg::ST_T_DIV: if (div_stat.done) state_in = baro_pkg::ST_T_FIN;
         baro_pkg::ST_T_FIN: state_in = baro_pkg::ST_DONE;
         baro_pkg::ST_P_B6:  state_in = baro_pkg::ST_P_SQ;
         baro_pkg::ST_P_SQ:  state_in = baro_pkg::ST_P_X1;
         baro_pkg::ST_P_X1:  state_in = baro_pkg::ST_P_B3;
         baro_pkg::ST_P_B3:  state_in = baro_pkg::ST_P_AC3;
         baro_pkg::ST_P_AC3: state_in = baro_pkg::ST_P_X3;
         baro_pkg::ST_P_X3:  state_in = baro_pkg::ST_P_B4;
         baro_pkg::ST_P_B4:  state_in = baro_pkg::ST_P_B7;
         baro_pkg::ST_P_B7:  state_in = (b4_ff == 32'd0) ? baro_pkg::ST_DONE : baro_pkg::ST_P_DIV;
         baro_pkg::ST_P_DIV: if (div_stat.done) state_in = baro_pkg::ST_P_P;
         baro_pkg::ST_P_P:   state_in = baro_pkg::ST_P_T;
         baro_pkg::ST_P_T:   state_in = baro_pkg::ST_P_X1B;
         baro_pkg::ST_P_X1B: state_in = baro_pkg::ST_P_FIN;
         baro_pkg::ST_P_FIN: state_in = baro_pkg::ST_DONE;
         baro_pkg::ST_DONE:  if (rsp_free) state_in = baro_pkg::ST_IDLE;
         default:            state_in = baro_pkg::ST_IDLE;
      endcase
   end

   // Datapath steps
   always_comb begin
      mul_a   = 32'd0;
      mul_b   = 32'd0;
      den     = t1_ff + baro_pkg::sx16(mc_md_ff[15:0]);
      x3      = 32'd0;
      up      = {8'd0, raw_ff} >> (4'd8 - {2'd0, oss_ff});
      b7      = 32'd0;
      tq      = 32'd0;
      x2      = 32'd0;
      b5_in   = b5_ff;
      b6_in   = b6_ff;
      sq_in   = sq_ff;
      t1_in   = t1_ff;
      b3_in   = b3_ff;
      b4_in   = b4_ff;
      p_in    = p_ff;
      msb_in  = msb_ff;
      val_in  = val_ff;
      stat_in = stat_ff;
      div_req.start     = 1'b0;
      div_req.is_signed = 1'b1;
      div_req.dividend  = baro_pkg::sx16(mc_md_ff[31:16]) << 11;
      div_req.divisor   = den;
      unique case (state_ff)
         baro_pkg::ST_T_MUL: begin
            mul_a = {16'd0, raw_ff[15:0]} - {16'd0, ac5_ac6_ff[15:0]};
            mul_b = {16'd0, ac5_ac6_ff[31:16]};
            t1_in = baro_pkg::asr(prod, 5'd15);
         end
         baro_pkg::ST_T_DEN: begin
            if (den == 32'd0) begin
               val_in  = 32'd0;
               stat_in = baro_pkg::STATUS_DIV0;
            end else begin
               div_req.start = 1'b1;
            end
         end
         baro_pkg::ST_T_DIV: begin
            if (div_stat.done) p_in = div_stat.quotient;
         end
         baro_pkg::ST_T_FIN: begin
            b5_in   = t1_ff + p_ff;
            val_in  = baro_pkg::asr(t1_ff + p_ff + 32'd8, 5'd4);
            stat_in = baro_pkg::STATUS_OK;
         end
         baro_pkg::ST_P_B6: begin
            b6_in = b5_ff - baro_pkg::B6_OFFSET;
         end
         baro_pkg::ST_P_SQ: begin
            mul_a = b6_ff;
            mul_b = b6_ff;
            sq_in = baro_pkg::sdiv_pow2(prod, 5'd12);
         end
         baro_pkg::ST_P_X1: begin
            mul_a = baro_pkg::sx16(b1_b2_ff[15:0]);
            mul_b = sq_ff;
            t1_in = baro_pkg::asr(prod, 5'd11);
         end
         baro_pkg::ST_P_B3: begin
            mul_a = baro_pkg::sx16(ac1_ac2_ff[15:0]);
            mul_b = b6_ff;
            x3    = t1_ff + baro_pkg::asr(prod, 5'd11);
            b3_in = baro_pkg::asr(
                       (((baro_pkg::sx16(ac1_ac2_ff[31:16]) << 2) + x3) << oss_ff) + 32'd2,
                       5'd2);
         end
         baro_pkg::ST_P_AC3: begin
            mul_a = baro_pkg::sx16(ac3_ac4_ff[31:16]);
            mul_b = b6_ff;
            t1_in = baro_pkg::sdiv_pow2(prod, 5'd13);
         end
         baro_pkg::ST_P_X3: begin
            mul_a = baro_pkg::sx16(b1_b2_ff[31:16]);
            mul_b = sq_ff;
            x2    = baro_pkg::sdiv_pow2(prod, 5'd16);
            t1_in = baro_pkg::sdiv_pow2(t1_ff + x2 + 32'd2, 5'd2);
         end
         baro_pkg::ST_P_B4: begin
            mul_a = {16'd0, ac3_ac4_ff[15:0]};
            mul_b = t1_ff + baro_pkg::X3_OFFSET;
            b4_in = prod >> 15;
         end
         baro_pkg::ST_P_B7: begin
            mul_a  = up - b3_ff;
            mul_b  = baro_pkg::P_SCALE >> oss_ff;
            b7     = prod;
            msb_in = b7[31];
            div_req.is_signed = 1'b0;
            div_req.dividend  = b7[31] ? b7 : (b7 << 1);
            div_req.divisor   = b4_ff;
            if (b4_ff == 32'd0) begin
               val_in  = 32'd0;
               stat_in = baro_pkg::STATUS_DIV0;
            end else begin
               div_req.start = 1'b1;
            end
         end
         baro_pkg::ST_P_DIV: begin
            if (div_stat.done) p_in = div_stat.quotient;
         end
         baro_pkg::ST_P_P: begin
            p_in = msb_ff ? (p_ff << 1) : p_ff;
         end
         baro_pkg::ST_P_T: begin
            tq    = baro_pkg::sdiv_pow2(p_ff, 5'd8);
            mul_a = tq;
            mul_b = tq;
            t1_in = prod;
         end
         baro_pkg::ST_P_X1B: begin
            mul_a = t1_ff;
            mul_b = baro_pkg::P_COEF_SQ;
            t1_in = baro_pkg::sdiv_pow2(prod, 5'd16);
         end
         baro_pkg::ST_P_FIN: begin
            mul_a   = baro_pkg::P_COEF_LIN;
            mul_b   = p_ff;
            x2      = baro_pkg::sdiv_pow2(prod, 5'd16);
            val_in  = p_ff + baro_pkg::sdiv_pow2(t1_ff + x2 + baro_pkg::P_OFFSET, 5'd4);
            stat_in = baro_pkg::STATUS_OK;
         end
         default: ;
      endcase
   end

   // Result register: load from the sequencer, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == baro_pkg::ST_DONE && rsp_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= baro_pkg::ST_IDLE;
         b5_ff        <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b5_ff        <= b5_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_opcode;
         raw_ff  <= req_raw_sample;
      end
      b6_ff   <= b6_in;
      sq_ff   <= sq_in;
      t1_ff   <= t1_in;
      b3_ff   <= b3_in;
      b4_ff   <= b4_in;
      p_ff    <= p_in;
      msb_ff  <= msb_in;
      val_ff  <= val_in;
      stat_ff <= stat_in;
      if (state_ff == baro_pkg::ST_DONE && rsp_free) begin
         rsp_kind_ff  <= kind_ff;
         rsp_value_ff <= val_ff;
         rsp_stat_ff  <= stat_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_kind_ff;
   assign rsp_compensated_value = $signed(rsp_value_ff);
   assign rsp_status            = rsp_stat_ff;

   // Divider completes only while the sequencer waits on it
   `ASSERT_CLK(a_div_done_wait, clock, reset, div_stat.done |-> (state_ff == baro_pkg::ST_T_DIV || state_ff == baro_pkg::ST_P_DIV), "divider done outside a wait state")
   // A zero-divisor result carries a zero value
   `ASSERT_CLK(a_div0_zero, clock, reset, (rsp_valid && rsp_status) |-> (rsp_compensated_value == 32'sd0), "zero-divisor result with nonzero value")
   // An accepted word starts the sequencer
   `ASSERT_CLK(a_accept_busy, clock, reset, req_take |=> (state_ff != baro_pkg::ST_IDLE), "accepted word left sequencer idle")
   // No divider start while it is still busy
   `ASSERT_NEVER(a_div_overlap, clock, reset, div_req.start && div_stat.busy, "divider restarted while busy")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives raw temperature and pressure words into the compensation block,
// predicts each compensated result in 32-bit wrapping integer arithmetic and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic        opcode;
      logic [23:0] raw;
   } sample_word_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        status;
   } comp_word_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 120;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [23:0] req_raw_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_result_kind;
   logic signed [31:0] rsp_compensated_value;
   logic        rsp_status;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // Predictor state
   logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
   logic [1:0]  oss_setting;
   logic [31:0] b5_kept;

   sample_word_type pending_words[$];
   comp_word_type   expected_words[$];
   int              error_count;
   int              idle_cycles;
   int              req_gap;
   int              rsp_gap;

   barometer_temp_pressure_compensation DUT (.*);

   // Generate clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [31:0] ext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] shr_arith(input logic [31:0] v, input int n);
      return 32'($signed(v) >>> n);
   endfunction

   // Truncating signed divide with the INT_MIN / -1 wrap; divisor is nonzero
   function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   // Compute the compensated word and update the kept B5
   function automatic comp_word_type compensate(input sample_word_type w);
      comp_word_type r;
      logic [31:0] ut, x1, x2, x3, den, b5, up, b6, sq, b3, b4, b7, p, t;
      r.kind   = w.opcode;
      r.value  = '0;
      r.status = baro_pkg::STATUS_OK;
      if (w.opcode == baro_pkg::OP_TEMP) begin
         ut  = {16'd0, w.raw[15:0]};
         x1  = shr_arith((ut - {16'd0, cal_ac5_ac6[15:0]}) * {16'd0, cal_ac5_ac6[31:16]}, 15);
         den = x1 + ext16(cal_mc_md[15:0]);
         if (den == 0) begin
            r.status = baro_pkg::STATUS_DIV0;
         end else begin
            b5      = x1 + div_trunc(ext16(cal_mc_md[31:16]) * 32'd2048, den);
            b5_kept = b5;
            r.value = shr_arith(b5 + 32'd8, 4);
         end
      end else begin
         up = {8'd0, w.raw} >> (8 - oss_setting);
         b6 = b5_kept - 32'd4000;
         sq = div_trunc(b6 * b6, 32'h1000);
         x1 = shr_arith(ext16(cal_b1_b2[15:0]) * sq, 11);
         x2 = shr_arith(ext16(cal_ac1_ac2[15:0]) * b6, 11);
         x3 = x1 + x2;
         b3 = shr_arith(((ext16(cal_ac1_ac2[31:16]) * 32'd4 + x3) << oss_setting) + 32'd2, 2);
         x1 = div_trunc(ext16(cal_ac3_ac4[31:16]) * b6, 32'h2000);
         x2 = div_trunc(ext16(cal_b1_b2[31:16]) * sq, 32'h10000);
         x3 = div_trunc(x1 + x2 + 32'd2, 32'd4);
         b4 = ({16'd0, cal_ac3_ac4[15:0]} * (x3 + 32'd32768)) / 32'h8000;
         b7 = (up - b3) * (32'd50000 >> oss_setting);
         if (b4 == 0) begin
            r.status = baro_pkg::STATUS_DIV0;
         end else begin
            p  = b7[31] ? (b7 / b4) * 32'd2 : (b7 * 32'd2) / b4;
            t  = div_trunc(p, 32'h100);
            x1 = div_trunc((t * t) * 32'd3038, 32'h10000);
            x2 = div_trunc(32'hFFFF_E343 * p, 32'h10000);
            r.value = p + div_trunc(x1 + x2 + 32'd3791, 32'h10);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Drive input words from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (req_valid && !req_stall) begin
         expected_words.push_back(compensate({req_opcode, req_raw_sample}));
         void'(pending_words.pop_front());
         req_valid <= 1'b0;
         req_gap   <= $urandom_range(0, 6);
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_words.size() > 0) begin
            req_valid      <= 1'b1;
            req_opcode     <= pending_words[0].opcode;
            req_raw_sample <= pending_words[0].raw;
         end
      end
   end

   // Check result words and draw receiver stalls
   always @(posedge clock) begin
      comp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_compensated_value, 32'd0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch("result_kind", {31'd0, rsp_result_kind},
                                  {31'd0, want.kind});
               if (rsp_compensated_value !== want.value)
                  report_mismatch("compensated_value", rsp_compensated_value, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", {31'd0, rsp_status}, {31'd0, want.status});
            end
            rsp_gap <= $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Count cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("barometer_temp_pressure_compensation verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         baro_pkg::REG_AC1_AC2: cal_ac1_ac2 = data;
         baro_pkg::REG_AC3_AC4: cal_ac3_ac4 = data;
         baro_pkg::REG_AC5_AC6: cal_ac5_ac6 = data;
         baro_pkg::REG_B1_B2:   cal_b1_b2   = data;
         baro_pkg::REG_MC_MD:   cal_mc_md   = data;
         baro_pkg::REG_OSS:     oss_setting = data[1:0];
         default: ;
      endcase
   endtask

   // Hold until every queued word has been returned
   task automatic drain;
      while (pending_words.size() > 0 || expected_words.size() > 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_word(input logic op, input logic [23:0] raw);
      sample_word_type w;
      w.opcode = op;
      w.raw    = raw;
      pending_words.push_back(w);
   endtask

   // Typical calibration with small random offsets
   task automatic load_typical_cal;
      write_reg(baro_pkg::REG_AC1_AC2, {16'(408 + $urandom_range(0, 200)), 16'hFFB8});
      write_reg(baro_pkg::REG_AC3_AC4, {16'hC6C1, 16'(32741 + $urandom_range(0, 300))});
      write_reg(baro_pkg::REG_AC5_AC6, {16'(32757 - $urandom_range(0, 20000)), 16'(23153)});
      write_reg(baro_pkg::REG_B1_B2,   {16'd6190, 16'd4});
      write_reg(baro_pkg::REG_MC_MD,   {16'h8001 + 16'($urandom_range(0, 100)), 16'(2868)});
   endtask

   task automatic random_words(input int count);
      repeat (count) begin
         if ($urandom_range(0, 2) == 0)
            add_word(baro_pkg::OP_TEMP, {8'($urandom), 16'(24000 + $urandom_range(0, 12000))});
         else if ($urandom_range(0, 9) == 0)
            add_word(1'($urandom_range(0, 1)), 24'($urandom));
         else
            add_word(baro_pkg::OP_PRESS, 24'(23843 * 256 + $urandom_range(0, 4000000)));
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_opcode  = 1'b0;
      req_raw_sample = '0;
      error_count = 0;
      idle_cycles = 0;
      cal_ac1_ac2 = '0; cal_ac3_ac4 = '0; cal_ac5_ac6 = '0;
      cal_b1_b2 = '0; cal_mc_md = '0;
      oss_setting = 2'd3;
      b5_kept     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: zero divisors, pressure before any temperature
      add_word(baro_pkg::OP_PRESS, 24'hFFFFFF);
      add_word(baro_pkg::OP_TEMP, 24'h000000);
      add_word(baro_pkg::OP_PRESS, 24'h000000);
      drain();

      // Typical calibration, field extremes and ignored upper temperature bits
      load_typical_cal();
      write_reg(baro_pkg::REG_OSS, 32'd0);
      add_word(baro_pkg::OP_PRESS, 24'h5D2300);
      add_word(baro_pkg::OP_TEMP, 24'h006C50);
      add_word(baro_pkg::OP_TEMP, 24'hFF6C50);
      add_word(baro_pkg::OP_PRESS, 24'h5D2300);
      add_word(baro_pkg::OP_TEMP, 24'h00FFFF);
      add_word(baro_pkg::OP_TEMP, 24'h000000);
      add_word(baro_pkg::OP_PRESS, 24'hFFFFFF);
      add_word(baro_pkg::OP_PRESS, 24'h000000);
      drain();

      // Temperature divisor zero: X1 = 0 with MD = 0, B5 must be kept
      write_reg(baro_pkg::REG_MC_MD, 32'hD4BD_0000);
      add_word(baro_pkg::OP_TEMP, 24'h005A71);
      add_word(baro_pkg::OP_PRESS, 24'hAAAAAA);
      drain();

      // Extreme calibration words to exercise wrapping
      write_reg(baro_pkg::REG_AC1_AC2, 32'h8000_7FFF);
      write_reg(baro_pkg::REG_AC3_AC4, 32'h7FFF_FFFF);
      write_reg(baro_pkg::REG_AC5_AC6, 32'hFFFF_0000);
      write_reg(baro_pkg::REG_B1_B2,   32'h8000_8000);
      write_reg(baro_pkg::REG_MC_MD,   32'h7FFF_8000);
      write_reg(baro_pkg::REG_OSS,     32'd3);
      add_word(baro_pkg::OP_TEMP, 24'h00FFFF);
      add_word(baro_pkg::OP_PRESS, 24'hFFFFFF);
      add_word(baro_pkg::OP_TEMP, 24'h555555);
      add_word(baro_pkg::OP_PRESS, 24'h555555);
      drain();

      // Random phases over all oversampling settings
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 6) begin
            write_reg(baro_pkg::REG_AC1_AC2, $urandom);
            write_reg(baro_pkg::REG_AC3_AC4, $urandom);
            write_reg(baro_pkg::REG_AC5_AC6, $urandom);
            write_reg(baro_pkg::REG_B1_B2,   $urandom);
            write_reg(baro_pkg::REG_MC_MD,   $urandom);
         end else begin
            load_typical_cal();
         end
         write_reg(baro_pkg::REG_OSS, 32'(phase % 4));
         random_words(60);
         drain();
      end

      if (error_count == 0)
         $display("barometer_temp_pressure_compensation verification clean");
      else
         $display("barometer_temp_pressure_compensation verification failed");
      $finish;
   end

endmodule
